// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion macros shared by the pid h-bridge speed control block
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define PID_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must hold in the cycle after a trigger
`define PID_ASSERT_NEXT(lbl, trig, cons, msg) \
  `PID_ASSERT(lbl, (trig) |=> (cons), msg)

`endif

// File: src/pid_hb_pkg.sv
// ----------------------------------------------------------------------------
// pid_hb_pkg
// constants, register codes and stage types of the pid h-bridge controller
// ----------------------------------------------------------------------------
`default_nettype none

package pid_hb_pkg;

  localparam int PWM_BITS       = 10;
  localparam int GAIN_FRAC_BITS = 12;

  localparam int SPEED_W = 24;
  localparam int GAIN_W  = 24;
  localparam int ERR_W   = SPEED_W + 1;
  localparam int INTEG_W = 15;
  localparam int DIFF_W  = ERR_W + 1;

  localparam int INTEGRAL_LIMIT = 10000;
  localparam int PERCENT_FULL   = 100;

  localparam int PE_W = ERR_W + GAIN_W;
  localparam int PI_W = INTEG_W + GAIN_W;
  localparam int PD_W = DIFF_W + GAIN_W;
  localparam int U_W  = PD_W + 2;

  // clamp limit of the controller output, 100 percent in gain fraction units
  localparam longint LIMIT = longint'(PERCENT_FULL) << GAIN_FRAC_BITS;
  localparam int     LIM_W = $clog2(LIMIT + 1);
  localparam int     MAG_W = LIM_W + PWM_BITS - GAIN_FRAC_BITS;

  // divide by 100 as multiply by reciprocal, error stays below 1/128
  localparam int              DIV_SHIFT = MAG_W + 7;
  localparam int              RECIP_W   = DIV_SHIFT - 6;
  localparam longint unsigned RECIP     = (64'd1 << DIV_SHIFT) / PERCENT_FULL + 1;
  localparam int              PRD_W     = MAG_W + RECIP_W;
  localparam int              Q_W       = PRD_W - DIV_SHIFT;

  localparam int     DUTY_W = PWM_BITS + 1;
  localparam longint FULL   = longint'(1) << PWM_BITS;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 16;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_TARGET_SPEED = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_LOOP_ENABLE  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_P       = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_I       = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_D       = 3'd4;

  typedef struct packed {
    logic                      valid;
    logic signed [ERR_W-1:0]   e;
    logic signed [INTEG_W-1:0] integ;
    logic signed [DIFF_W-1:0]  diff;
  } err_t;

  typedef struct packed {
    logic                   valid;
    logic signed [PE_W-1:0] pe;
    logic signed [PI_W-1:0] pi;
    logic signed [PD_W-1:0] pd;
  } prod_t;

  typedef struct packed {
    logic             valid;
    logic             neg;
    logic [MAG_W-1:0] m;
  } mag_t;

  typedef struct packed {
    logic              valid;
    logic [DUTY_W-1:0] duty;
    logic              drive_a;
    logic              drive_b;
  } res_t;

endpackage

`default_nettype wire

// File: src/pid_hb_err.sv
// ----------------------------------------------------------------------------
// pid_hb_err
// error, clamped integral and error difference, holds the loop state
// ----------------------------------------------------------------------------
`default_nettype none

module pid_hb_err (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 advance,
  input  wire logic                                 load,
  input  wire logic signed [pid_hb_pkg::SPEED_W-1:0] speed,
  input  wire logic signed [pid_hb_pkg::SPEED_W-1:0] target,
  output pid_hb_pkg::err_t                           err
);
  import pid_hb_pkg::*;

  localparam logic signed [DIFF_W-1:0] LIM_P = DIFF_W'(INTEGRAL_LIMIT);
  localparam logic signed [DIFF_W-1:0] LIM_N = -LIM_P;

  logic signed [INTEG_W-1:0] integ_r;
  logic signed [ERR_W-1:0]   prev_r;
  err_t                      err_r;

  logic signed [ERR_W-1:0]  e;
  logic signed [DIFF_W-1:0] sum;
  logic signed [DIFF_W-1:0] sum_cl;
  logic signed [DIFF_W-1:0] diff;

  always_comb begin
    e    = ERR_W'(target) - ERR_W'(speed);
    sum  = DIFF_W'(integ_r) + DIFF_W'(e);
    diff = DIFF_W'(e) - DIFF_W'(prev_r);
    if (sum > LIM_P) begin
      sum_cl = LIM_P;
    end else if (sum < LIM_N) begin
      sum_cl = LIM_N;
    end else begin
      sum_cl = sum;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      err_r.e     <= e;
      err_r.integ <= INTEG_W'(sum_cl);
      err_r.diff  <= diff;
    end
    if (!rst_n) begin
      integ_r     <= '0;
      prev_r      <= '0;
      err_r.valid <= 1'b0;
    end else if (advance) begin
      err_r.valid <= load;
      if (load) begin
        integ_r <= INTEG_W'(sum_cl);
        prev_r  <= e;
      end
    end
  end

  assign err = err_r;

endmodule

`default_nettype wire

// File: src/pid_hb_mul.sv
// ----------------------------------------------------------------------------
// pid_hb_mul
// the three gain products, registered
// ----------------------------------------------------------------------------
`default_nettype none

module pid_hb_mul (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                advance,
  input  wire pid_hb_pkg::err_t                     err,
  input  wire logic signed [pid_hb_pkg::GAIN_W-1:0] gain_p,
  input  wire logic signed [pid_hb_pkg::GAIN_W-1:0] gain_i,
  input  wire logic signed [pid_hb_pkg::GAIN_W-1:0] gain_d,
  output pid_hb_pkg::prod_t                         prod
);
  import pid_hb_pkg::*;

  prod_t prod_r;

  logic signed [PE_W-1:0] pe_nxt;
  logic signed [PI_W-1:0] pi_nxt;
  logic signed [PD_W-1:0] pd_nxt;

  always_comb begin
    pe_nxt = $signed(err.e) * gain_p;
    pi_nxt = $signed(err.integ) * gain_i;
    pd_nxt = $signed(err.diff) * gain_d;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      prod_r.pe <= pe_nxt;
      prod_r.pi <= pi_nxt;
      prod_r.pd <= pd_nxt;
    end
    if (!rst_n) begin
      prod_r.valid <= 1'b0;
    end else if (advance) begin
      prod_r.valid <= err.valid;
    end
  end

  assign prod = prod_r;

endmodule

`default_nettype wire

// File: src/pid_hb_scale.sv
// ----------------------------------------------------------------------------
// pid_hb_scale
// sum of products, clamp to full scale, magnitude scaled to pwm range
// ----------------------------------------------------------------------------
`default_nettype none

module pid_hb_scale (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              advance,
  input  wire pid_hb_pkg::prod_t prod,
  output pid_hb_pkg::mag_t       mag
);
  import pid_hb_pkg::*;

  localparam logic signed [U_W-1:0] U_LIM_P = U_W'(LIMIT);
  localparam logic signed [U_W-1:0] U_LIM_N = -U_LIM_P;

  mag_t mag_r;

  logic signed [U_W-1:0]      u;
  logic signed [U_W-1:0]      u_cl;
  logic signed [U_W-1:0]      u_abs;
  logic [LIM_W+PWM_BITS-1:0]  shifted;
  logic                       neg;

  always_comb begin
    u   = U_W'($signed(prod.pe)) + U_W'($signed(prod.pi)) + U_W'($signed(prod.pd));
    neg = u[U_W-1];
    if (u > U_LIM_P) begin
      u_cl = U_LIM_P;
    end else if (u < U_LIM_N) begin
      u_cl = U_LIM_N;
    end else begin
      u_cl = u;
    end
    u_abs   = neg ? -u_cl : u_cl;
    shifted = {u_abs[LIM_W-1:0], {PWM_BITS{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      mag_r.neg <= neg;
      mag_r.m   <= shifted[LIM_W+PWM_BITS-1:GAIN_FRAC_BITS];
    end
    if (!rst_n) begin
      mag_r.valid <= 1'b0;
    end else if (advance) begin
      mag_r.valid <= prod.valid;
    end
  end

  assign mag = mag_r;

endmodule

`default_nettype wire

// File: src/pid_hb_out.sv
// ----------------------------------------------------------------------------
// pid_hb_out
// divide by 100, duty limit and bridge direction, result register
// ----------------------------------------------------------------------------
`default_nettype none

module pid_hb_out (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             advance,
  input  wire pid_hb_pkg::mag_t mag,
  output pid_hb_pkg::res_t      res
);
  import pid_hb_pkg::*;

  res_t res_r;

  logic [PRD_W-1:0]  qprod;
  logic [Q_W-1:0]    q;
  logic              nz;
  logic [DUTY_W-1:0] duty_nxt;

  always_comb begin
    qprod = PRD_W'(mag.m) * PRD_W'(RECIP_W'(RECIP));
    q     = qprod[PRD_W-1:DIV_SHIFT];
    nz    = (q != '0);
    if (q > Q_W'(FULL)) begin
      duty_nxt = DUTY_W'(FULL);
    end else begin
      duty_nxt = DUTY_W'(q);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r.duty    <= duty_nxt;
      res_r.drive_a <= mag.neg & nz;
      res_r.drive_b <= ~mag.neg & nz;
    end
    if (!rst_n) begin
      res_r.valid <= 1'b0;
    end else if (advance) begin
      res_r.valid <= mag.valid;
    end
  end

  assign res = res_r;

endmodule

`default_nettype wire

// File: src/pid_hbridge_speed_control_top.sv
// ----------------------------------------------------------------------------
// pid_hbridge_speed_control_top
// pid speed controller with integral clamp driving an h-bridge
// ----------------------------------------------------------------------------
// usage
//   in_*  : one item per control tick, tdata holds the measured speed
//   out_* : one item per enabled tick, duty magnitude plus leg a / leg b bits
//   cfg_* : apb register port, setpoint, enable and the three q12 gains
//   out_tvalid rises once an accepted item has passed one register each for
//   the error, multiply, scale and divide stages
//   throughput: one item per cycle while no result waits or out_tready is high, the whole pipeline advances together
//   ticks taken while loop_enable is low produce no item and leave the
//   integral and previous error untouched
//   reset clears the config registers, the loop state and all stage valid bits
//   when the receiver stalls with a result waiting, the pipeline holds and
//   in_tready drops until the result is taken
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module pid_hbridge_speed_control_top (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  // in_tdata: measured_speed[23:0]
  input  wire logic                                  in_tvalid,
  output logic                                       in_tready,
  input  wire logic [pid_hb_pkg::IN_TDATA_W-1:0]     in_tdata,
  // out_tdata: duty[10:0], drive_a[11], drive_b[12], zero[15:13]
  output logic                                       out_tvalid,
  input  wire logic                                  out_tready,
  output logic [pid_hb_pkg::OUT_TDATA_W-1:0]         out_tdata,
  input  wire logic                                  cfg_psel,
  input  wire logic                                  cfg_penable,
  input  wire logic                                  cfg_pwrite,
  input  wire logic [pid_hb_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  wire logic [pid_hb_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [pid_hb_pkg::CFG_DATA_W-1:0]          cfg_prdata,
  output logic                                       cfg_pready
);
  import pid_hb_pkg::*;

  logic signed [SPEED_W-1:0] target_speed_r;
  logic                      loop_enable_r;
  logic signed [GAIN_W-1:0]  gain_p_r;
  logic signed [GAIN_W-1:0]  gain_i_r;
  logic signed [GAIN_W-1:0]  gain_d_r;

  logic                 cfg_wr;
  logic [REG_IDX_W-1:0] cfg_idx;
  logic                 advance;
  logic                 load;

  err_t  err;
  prod_t prod;
  mag_t  mag;
  res_t  res;

  // register port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx    = cfg_paddr[CFG_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_speed_r <= '0;
      loop_enable_r  <= 1'b0;
      gain_p_r       <= '0;
      gain_i_r       <= '0;
      gain_d_r       <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_TARGET_SPEED: target_speed_r <= cfg_pwdata[SPEED_W-1:0];
        REG_LOOP_ENABLE:  loop_enable_r  <= cfg_pwdata[0];
        REG_GAIN_P:       gain_p_r       <= cfg_pwdata[GAIN_W-1:0];
        REG_GAIN_I:       gain_i_r       <= cfg_pwdata[GAIN_W-1:0];
        REG_GAIN_D:       gain_d_r       <= cfg_pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_TARGET_SPEED: cfg_prdata = CFG_DATA_W'($unsigned(target_speed_r));
      REG_LOOP_ENABLE:  cfg_prdata = CFG_DATA_W'(loop_enable_r);
      REG_GAIN_P:       cfg_prdata = CFG_DATA_W'($unsigned(gain_p_r));
      REG_GAIN_I:       cfg_prdata = CFG_DATA_W'($unsigned(gain_i_r));
      REG_GAIN_D:       cfg_prdata = CFG_DATA_W'($unsigned(gain_d_r));
      default:          cfg_prdata = '0;
    endcase
  end

  // pipeline moves whenever the result register is free or being taken
  assign advance   = ~res.valid | out_tready;
  assign in_tready = advance;
  assign load      = in_tvalid & loop_enable_r;

  pid_hb_err u_err (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .load    (load),
    .speed   ($signed(in_tdata[SPEED_W-1:0])),
    .target  (target_speed_r),
    .err     (err)
  );

  pid_hb_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .err     (err),
    .gain_p  (gain_p_r),
    .gain_i  (gain_i_r),
    .gain_d  (gain_d_r),
    .prod    (prod)
  );

  pid_hb_scale u_scale (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .prod    (prod),
    .mag     (mag)
  );

  pid_hb_out u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .mag     (mag),
    .res     (res)
  );

  assign out_tvalid = res.valid;
  assign out_tdata  = {{(OUT_TDATA_W-DUTY_W-2){1'b0}}, res.drive_b, res.drive_a, res.duty};

  `PID_ASSERT(a_drive_matches_duty, out_tvalid |-> ((res.duty != '0) == (res.drive_a || res.drive_b)), "drive bits disagree with duty")
  `PID_ASSERT(a_duty_in_range, out_tvalid |-> (res.duty <= DUTY_W'(FULL)), "duty above full scale")
  `PID_ASSERT(a_stall_blocks_input, (out_tvalid && !out_tready) |-> !in_tready, "input taken during stall")
  `PID_ASSERT_NEXT(a_disabled_tick_dropped, in_tvalid && in_tready && !loop_enable_r, !err.valid, "disabled tick entered pipeline")

endmodule

`default_nettype wire
